[rtl/ttc_pkg.sv]
// Shared constants, codes and arithmetic helpers of the terrain transmittance correction.
package ttc_pkg;

	localparam int unsigned FULL_TURN    = 23040;
	localparam int unsigned QUARTER_TURN = 5760;
	localparam int unsigned EIGHTH_TURN  = 2880;
	localparam int unsigned RAD_PER_UNIT = 292818;

	localparam logic [30:0] ONE30  = 31'h4000_0000;
	localparam logic [30:0] C_2    = 31'(64'h4000_0000 / 2);
	localparam logic [30:0] C_6    = 31'(64'h4000_0000 / 6);
	localparam logic [30:0] C_24   = 31'(64'h4000_0000 / 24);
	localparam logic [30:0] C_120  = 31'(64'h4000_0000 / 120);
	localparam logic [30:0] C_720  = 31'(64'h4000_0000 / 720);
	localparam logic [30:0] C_5040 = 31'(64'h4000_0000 / 5040);
	localparam logic [30:0] LN2_Q30 = 31'd744261118;

	localparam int unsigned LOG_FRAC       = 24;
	localparam int unsigned EXP_TERMS      = 12;
	localparam int unsigned VIEW_COS_FLOOR = 3;
	localparam int unsigned TDOWN_MAX      = 262143;

	// Latency of the sine/cosine pipeline.
	localparam int unsigned CS_LAT = 9;

	// Divider widths of the downward and upward paths.
	localparam int unsigned TDN_NUM_W = 46;
	localparam int unsigned TUP_NUM_W = 44;
	localparam int unsigned DIV_DEN_W = 16;

	localparam logic [1:0] REG_SUN_ZENITH   = 2'd0;
	localparam logic [1:0] REG_SUN_AZIMUTH  = 2'd1;
	localparam logic [1:0] REG_COS_SUN      = 2'd2;
	localparam logic [1:0] REG_COS_VIEW_REF = 2'd3;

	// Unsigned Q30 product, truncated.
	function automatic logic [30:0] mul30(input logic [30:0] a, input logic [30:0] b);
		logic [61:0] p;
		p = 62'(a) * 62'(b);
		return p[60:30];
	endfunction

	// Signed Q30 product taken on magnitudes, truncated toward zero.
	function automatic logic signed [31:0] smul30(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic [30:0] ua;
		logic [30:0] ub;
		logic [30:0] m;
		ua = a[31] ? 31'(-a) : a[30:0];
		ub = b[31] ? 31'(-b) : b[30:0];
		m  = mul30(ua, ub);
		return (a[31] ^ b[31]) ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	// Q30 to Q15 with the magnitude rounded half up.
	function automatic logic signed [18:0] q30_to_q15(input logic signed [32:0] v);
		logic [32:0] mag;
		logic [33:0] rnd;
		mag = v[32] ? 33'(-v) : 33'(v);
		rnd = 34'(mag) + 34'd16384;
		return v[32] ? -$signed({1'b0, rnd[32:15]}) : $signed({1'b0, rnd[32:15]});
	endfunction

endpackage

[rtl/terrain_transmittance_correction_top.sv]
// Top level of the terrain transmittance correction pipeline with its register port.
// One pixel transfer is accepted in every clock cycle: busy stays low, and each result
// appears on the result ports for exactly one cycle with done high. The latency is set
// by the upward path: a 24-stage log2 squaring chain, a 44-stage divider for the power-law
// exponent and a 36-stage exp2 series; the downward path runs through a 46-stage divider in
// parallel and is delayed to match. The receiver cannot hold results off, so it must take
// one transfer per cycle. The user must write sun angles and reference cosines through the
// register port only while no pixel is in flight; the block itself does not enforce this.
module terrain_transmittance_correction_top
	import ttc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [12:0]        slope,
	input  logic [14:0]        aspect,
	input  logic [15:0]        t_down_total,
	input  logic [15:0]        t_down_direct,
	input  logic [15:0]        t_up_reference,
	input  logic [12:0]        view_zenith,
	output logic               done,
	output logic signed [16:0] cos_local_incidence,
	output logic [15:0]        sky_view,
	output logic [17:0]        t_down_effective,
	output logic               t_down_saturated,
	output logic               in_shadow,
	output logic [15:0]        t_up_pixel,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// Stage of the final output register.
	localparam int unsigned LAT = 109;

	typedef struct packed {
		logic signed [16:0] ci;
		logic [15:0]        sky;
		logic               shadow;
	} geo_t;

	typedef struct packed {
		geo_t        geo;
		logic [17:0] tde;
		logic        sat;
	} down_t;

	typedef struct packed {
		logic [30:0] u;
		logic [4:0]  nsh;
		logic        zero;
	} expc_t;

	// Configuration registers.
	logic [12:0] sun_zenith_q;
	logic [14:0] sun_azimuth_q;
	logic [15:0] cos_sun_zenith_q;
	logic [15:0] cos_view_reference_q;
	logic        cfg_wr;
	logic [15:0] cref_floor;
	logic [15:0] sun_den;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sun_zenith_q         <= '0;
			sun_azimuth_q        <= '0;
			cos_sun_zenith_q     <= 16'd32768;
			cos_view_reference_q <= 16'd32768;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SUN_ZENITH:   sun_zenith_q         <= pwdata[12:0];
				REG_SUN_AZIMUTH:  sun_azimuth_q        <= pwdata[14:0];
				REG_COS_SUN:      cos_sun_zenith_q     <= pwdata[15:0];
				REG_COS_VIEW_REF: cos_view_reference_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SUN_ZENITH:   prdata = {19'd0, sun_zenith_q};
			REG_SUN_AZIMUTH:  prdata = {17'd0, sun_azimuth_q};
			REG_COS_SUN:      prdata = {16'd0, cos_sun_zenith_q};
			REG_COS_VIEW_REF: prdata = {16'd0, cos_view_reference_q};
			default:          prdata = '0;
		endcase
	end

	// Floors applied to the configured cosines.
	assign cref_floor = (cos_view_reference_q < 16'(VIEW_COS_FLOOR)) ? 16'(VIEW_COS_FLOOR)
		: cos_view_reference_q;
	assign sun_den = (cos_sun_zenith_q == 16'd0) ? 16'd1 : cos_sun_zenith_q;

	// Valid bits travel alongside the data through every stage.
	logic in_accept;
	logic v_s [LAT-1];
	assign in_accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT - 1; i++) begin
				v_s[i] <= 1'b0;
			end
			done <= 1'b0;
		end else begin
			v_s[0] <= in_accept;
			for (int i = 1; i < LAT - 1; i++) begin
				v_s[i] <= v_s[i-1];
			end
			done <= v_s[LAT-2];
		end
	end

	// Four sine/cosine pipelines: sun zenith, slope, relative azimuth, view zenith.
	logic [16:0]        rel_az;
	logic signed [31:0] cz_s9, sz_s9, cs_s9, ss_s9, cd_s9, cv_s9;

	assign rel_az = 17'(sun_azimuth_q) + 17'(2 * FULL_TURN) - 17'(aspect);

	ttc_cossin u_cs_sun (.clk(clk), .angle(17'(sun_zenith_q)), .cos_o(cz_s9), .sin_o(sz_s9));
	ttc_cossin u_cs_slope (.clk(clk), .angle(17'(slope)), .cos_o(cs_s9), .sin_o(ss_s9));
	ttc_cossin u_cs_rel (.clk(clk), .angle(rel_az), .cos_o(cd_s9), .sin_o());
	ttc_cossin u_cs_view (.clk(clk), .angle(17'(view_zenith)), .cos_o(cv_s9), .sin_o());

	// Stage 1: transmittance inputs and the log2 normalization.
	logic [15:0] dif_s1, dir_s1, tup_s1;
	logic        pass_s1;
	logic [3:0]  p_s1;
	logic [30:0] z_s1;
	logic [14:0] mant;
	logic [3:0]  msb;

	assign mant = t_up_reference[14:0];

	always_comb begin
		msb = '0;
		for (int i = 0; i < 15; i++) begin
			if (mant[i]) begin
				msb = 4'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		dif_s1  <= (t_down_total > t_down_direct) ? t_down_total - t_down_direct : 16'd0;
		dir_s1  <= t_down_direct;
		tup_s1  <= t_up_reference;
		pass_s1 <= (t_up_reference == 16'd0) || t_up_reference[15];
		p_s1    <= msb;
		z_s1    <= 31'(31'(mant) << (5'd30 - 5'(msb)));
	end

	// Stages 2..12 carry the downward inputs; stage 13 reads them.
	logic [15:0] dif_pipe_s [11];
	logic [15:0] dir_pipe_s [11];

	always_ff @(posedge clk) begin
		dif_pipe_s[0] <= dif_s1;
		dir_pipe_s[0] <= dir_s1;
		for (int i = 1; i < 11; i++) begin
			dif_pipe_s[i] <= dif_pipe_s[i-1];
			dir_pipe_s[i] <= dir_pipe_s[i-1];
		end
	end

	// Stages 10..12: local incidence cosine and skyview factor.
	logic signed [31:0] p1_s10, p2_s10, cd_s10, cs_s10, p1_s11, p3_s11, cs_s11;
	logic [15:0]        cpx_s10;
	logic signed [18:0] cv_q15;
	logic signed [32:0] ci30;
	logic signed [18:0] ci_q15;
	logic signed [32:0] sky_sum;
	geo_t               geo_s12;
	geo_t               geo_next;

	assign cv_q15 = q30_to_q15(33'(cv_s9));
	assign ci30   = 33'(p1_s11) + 33'(p3_s11);
	assign ci_q15 = q30_to_q15(ci30);
	assign sky_sum = 33'sd1073741824 + 33'(cs_s11) + 33'sd32768;

	always_comb begin
		// The incidence cosine is clamped to one full unit either way.
		if (ci_q15 > 19'sd32768) begin
			geo_next.ci = 17'sd32767 + 17'sd1;
		end else if (ci_q15 < -19'sd32768) begin
			geo_next.ci = -17'sd32768;
		end else begin
			geo_next.ci = 17'(ci_q15);
		end
		geo_next.shadow = (ci_q15 <= 19'sd0);
		geo_next.sky = (sky_sum[32:16] > 17'd32768) ? 16'd32768 : sky_sum[31:16];
	end

	always_ff @(posedge clk) begin
		p1_s10  <= smul30(cz_s9, cs_s9);
		p2_s10  <= smul30(sz_s9, ss_s9);
		cd_s10  <= cd_s9;
		cs_s10  <= cs_s9;
		cpx_s10 <= (cv_q15 < 19'sd3) ? 16'(VIEW_COS_FLOOR) : cv_q15[15:0];
		p1_s11  <= p1_s10;
		p3_s11  <= smul30(p2_s10, cd_s10);
		cs_s11  <= cs_s10;
		geo_s12 <= geo_next;
	end

	// Stage 13: diffuse product and the direct-term division operands.
	logic [31:0]          difsky_s13;
	logic [TDN_NUM_W-1:0] dnum_s13;
	logic [15:0]          dden_s13;
	logic [31:0]          dir_ci;
	logic [TDN_NUM_W-1:0] dquot;

	assign dir_ci = 32'(dir_pipe_s[10]) * 32'(geo_s12.ci[15:0]);

	always_ff @(posedge clk) begin
		difsky_s13 <= 32'(dif_pipe_s[10]) * 32'(geo_s12.sky);
		// In shadow the direct term is dropped.
		dnum_s13   <= geo_s12.shadow ? '0 : {dir_ci[30:0], 15'd0};
		dden_s13   <= sun_den;
	end

	ttc_div #(.NUM_W(TDN_NUM_W), .DEN_W(DIV_DEN_W)) u_div_down (
		.clk(clk), .num(dnum_s13), .den(dden_s13), .quot(dquot)
	);

	// Stages 13..59 carry the geometry; stages 14..59 the diffuse product.
	geo_t        geo_pipe_s    [47];
	logic [31:0] difsky_pipe_s [46];

	always_ff @(posedge clk) begin
		geo_pipe_s[0]    <= geo_s12;
		difsky_pipe_s[0] <= difsky_s13;
		for (int i = 1; i < 47; i++) begin
			geo_pipe_s[i] <= geo_pipe_s[i-1];
		end
		for (int i = 1; i < 46; i++) begin
			difsky_pipe_s[i] <= difsky_pipe_s[i-1];
		end
	end

	// Stage 60: sum, round to Q15 and saturate.
	logic [47:0] acc;
	logic [32:0] tde_raw;
	down_t       down_s60;
	down_t       down_pipe_s [48];

	assign acc     = 48'(difsky_pipe_s[45]) + 48'(dquot) + 48'd16384;
	assign tde_raw = acc[47:15];

	always_ff @(posedge clk) begin
		down_s60.geo <= geo_pipe_s[46];
		down_s60.sat <= tde_raw > 33'(TDOWN_MAX);
		down_s60.tde <= (tde_raw > 33'(TDOWN_MAX)) ? 18'(TDOWN_MAX) : tde_raw[17:0];
		down_pipe_s[0] <= down_s60;
		for (int i = 1; i < 48; i++) begin
			down_pipe_s[i] <= down_pipe_s[i-1];
		end
	end

	// Stages 2..25: -log2 by repeated squaring, one fraction bit per stage.
	logic [30:0]         lz_s [LOG_FRAC];
	logic [LOG_FRAC-1:0] lf_s [LOG_FRAC];
	logic [3:0]          lp_s [LOG_FRAC];

	for (genvar j = 0; j < LOG_FRAC; j++) begin : g_log
		logic [30:0]         z_in;
		logic [LOG_FRAC-1:0] f_in;
		logic [3:0]          p_in;
		logic [61:0]         zz;
		if (j == 0) begin : g_first
			assign z_in = z_s1;
			assign f_in = '0;
			assign p_in = p_s1;
		end else begin : g_next
			assign z_in = lz_s[j-1];
			assign f_in = lf_s[j-1];
			assign p_in = lp_s[j-1];
		end
		assign zz = 62'(z_in) * 62'(z_in);
		always_ff @(posedge clk) begin
			lp_s[j] <= p_in;
			// A square of two or more halves and contributes a one bit.
			if (zz[61]) begin
				lz_s[j] <= zz[61:31];
				lf_s[j] <= {f_in[LOG_FRAC-2:0], 1'b1};
			end else begin
				lz_s[j] <= zz[60:30];
				lf_s[j] <= {f_in[LOG_FRAC-2:0], 1'b0};
			end
		end
	end

	// Stages 11..26 carry the floored pixel view cosine.
	logic [15:0] cpx_pipe_s [16];

	always_ff @(posedge clk) begin
		cpx_pipe_s[0] <= cpx_s10;
		for (int i = 1; i < 16; i++) begin
			cpx_pipe_s[i] <= cpx_pipe_s[i-1];
		end
	end

	// Stages 26..27: log value and the exponent division operands.
	logic [27:0]          lval_s26;
	logic [TUP_NUM_W-1:0] unum_s27;
	logic [15:0]          uden_s27;
	logic [TUP_NUM_W-1:0] yq;

	always_ff @(posedge clk) begin
		lval_s26 <= 28'hF00_0000 - {lp_s[LOG_FRAC-1], lf_s[LOG_FRAC-1]};
		unum_s27 <= TUP_NUM_W'(lval_s26) * TUP_NUM_W'(cref_floor);
		uden_s27 <= cpx_pipe_s[15];
	end

	ttc_div #(.NUM_W(TUP_NUM_W), .DEN_W(DIV_DEN_W)) u_div_up (
		.clk(clk), .num(unum_s27), .den(uden_s27), .quot(yq)
	);

	// Stage 72: split the exponent into octaves and a fraction scaled by ln 2.
	expc_t expc_s72;
	expc_t expc_pipe_s [36];

	always_ff @(posedge clk) begin
		expc_s72.u    <= mul30({1'b0, yq[LOG_FRAC-1:0], 6'd0}, LN2_Q30);
		expc_s72.zero <= (yq[TUP_NUM_W-1:LOG_FRAC] >= (TUP_NUM_W - LOG_FRAC)'(31));
		expc_s72.nsh  <= yq[LOG_FRAC+4:LOG_FRAC];
		expc_pipe_s[0] <= expc_s72;
		for (int i = 1; i < 36; i++) begin
			expc_pipe_s[i] <= expc_pipe_s[i-1];
		end
	end

	// Stages 73..108: exp series in Horner form, three stages per term.
	logic [30:0] ep_s  [EXP_TERMS];
	logic [30:0] ep2_s [EXP_TERMS];
	logic [30:0] eq_s  [EXP_TERMS];
	logic [30:0] et_s  [EXP_TERMS];

	for (genvar j = 0; j < EXP_TERMS; j++) begin : g_exp
		localparam int unsigned K = EXP_TERMS - j;
		localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);
		logic [30:0] t_in;
		logic [30:0] u_in;
		logic [63:0] qp;
		logic [30:0] rem;
		if (j == 0) begin : g_first
			assign t_in = ONE30;
			assign u_in = expc_s72.u;
		end else begin : g_next
			assign t_in = et_s[j-1];
			assign u_in = expc_pipe_s[3*j-1].u;
		end
		assign qp  = 64'(ep_s[j]) * 64'(RECIP);
		assign rem = ep2_s[j] - 31'(eq_s[j] * 31'(K));
		always_ff @(posedge clk) begin
			ep_s[j]  <= mul30(u_in, t_in);
			ep2_s[j] <= ep_s[j];
			// The reciprocal estimate is at most one short of the quotient.
			eq_s[j]  <= qp[62:32];
			et_s[j]  <= ONE30 - ((rem >= 31'(K)) ? eq_s[j] + 31'd1 : eq_s[j]);
		end
	end

	// Stages 2..108 carry the upward input and its passthrough flag.
	logic [15:0] tup_pipe_s  [LAT-2];
	logic        pass_pipe_s [LAT-2];

	always_ff @(posedge clk) begin
		tup_pipe_s[0]  <= tup_s1;
		pass_pipe_s[0] <= pass_s1;
		for (int i = 1; i < LAT - 2; i++) begin
			tup_pipe_s[i]  <= tup_pipe_s[i-1];
			pass_pipe_s[i] <= pass_pipe_s[i-1];
		end
	end

	// Stage 109: output registers.
	logic [30:0] t_shift;
	logic [31:0] t_round;

	assign t_shift = et_s[EXP_TERMS-1] >> expc_pipe_s[35].nsh;
	assign t_round = 32'(t_shift) + 32'd16384;

	always_ff @(posedge clk) begin
		cos_local_incidence <= down_pipe_s[47].geo.ci;
		sky_view            <= down_pipe_s[47].geo.sky;
		in_shadow           <= down_pipe_s[47].geo.shadow;
		t_down_effective    <= down_pipe_s[47].tde;
		t_down_saturated    <= down_pipe_s[47].sat;
		if (pass_pipe_s[LAT-3]) begin
			t_up_pixel <= tup_pipe_s[LAT-3];
		end else if (expc_pipe_s[35].zero) begin
			t_up_pixel <= '0;
		end else begin
			t_up_pixel <= t_round[30:15];
		end
	end

	// Every result transfer traces back to an accepted start.
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(in_accept, LAT))
		else $error("result transfer without a matching start");

	// The shadow flag agrees with the sign of the incidence cosine.
	a_shadow_sign: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (in_shadow == (cos_local_incidence <= 17'sd0)))
		else $error("shadow flag disagrees with incidence cosine");

	// A clipped downward transmittance sits at full scale.
	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && t_down_saturated) |-> (t_down_effective == 18'(TDOWN_MAX)))
		else $error("saturated downward transmittance not at full scale");

endmodule

[rtl/ttc_cossin.sv]
// Pipelined cosine and sine of an angle in 1/64 degree, Q30 results.
module ttc_cossin
	import ttc_pkg::*;
(
	input  logic               clk,
	input  logic [16:0]        angle,
	output logic signed [31:0] cos_o,
	output logic signed [31:0] sin_o
);

	logic [14:0] am_s1;
	logic [11:0] ro_s2;
	logic [1:0]  quad_s2, quad_s3, quad_s4, quad_s5, quad_s6, quad_s7, quad_s8;
	logic        swap_s2, swap_s3, swap_s4, swap_s5, swap_s6, swap_s7, swap_s8;
	logic [30:0] x_s3, x_s4, x_s5, x_s6, x_s7;
	logic [30:0] x2_s4, x2_s5, x2_s6;
	logic [30:0] t_s5, u_s5, t_s6, u_s6;
	logic [30:0] c_s7, u_s7, c_s8, s_s8;
	logic [14:0] r_full;
	logic [1:0]  quad;
	logic [30:0] c0, s0;

	always_comb begin
		if (am_s1 >= 15'(3 * QUARTER_TURN)) begin
			quad = 2'd3;
		end else if (am_s1 >= 15'(2 * QUARTER_TURN)) begin
			quad = 2'd2;
		end else if (am_s1 >= 15'(QUARTER_TURN)) begin
			quad = 2'd1;
		end else begin
			quad = 2'd0;
		end
		r_full = am_s1 - 15'(quad) * 15'(QUARTER_TURN);
	end

	always_comb begin
		c0 = swap_s8 ? s_s8 : c_s8;
		s0 = swap_s8 ? c_s8 : s_s8;
	end

	always_ff @(posedge clk) begin
		// Reduce modulo a full turn; the relative azimuth can reach past three turns.
		if (angle >= 17'(3 * FULL_TURN)) begin
			am_s1 <= 15'(angle - 17'(3 * FULL_TURN));
		end else if (angle >= 17'(2 * FULL_TURN)) begin
			am_s1 <= 15'(angle - 17'(2 * FULL_TURN));
		end else if (angle >= 17'(FULL_TURN)) begin
			am_s1 <= 15'(angle - 17'(FULL_TURN));
		end else begin
			am_s1 <= angle[14:0];
		end
		// Fold to an octant.
		quad_s2 <= quad;
		swap_s2 <= r_full > 15'(EIGHTH_TURN);
		ro_s2   <= (r_full > 15'(EIGHTH_TURN)) ? 12'(15'(QUARTER_TURN) - r_full)
			: r_full[11:0];
		x_s3  <= 31'(ro_s2) * 31'(RAD_PER_UNIT);
		x2_s4 <= mul30(x_s3, x_s3);
		t_s5  <= C_24 - mul30(x2_s4, C_720);
		u_s5  <= C_120 - mul30(x2_s4, C_5040);
		t_s6  <= C_2 - mul30(x2_s5, t_s5);
		u_s6  <= C_6 - mul30(x2_s5, u_s5);
		c_s7  <= ONE30 - mul30(x2_s6, t_s6);
		u_s7  <= ONE30 - mul30(x2_s6, u_s6);
		c_s8  <= c_s7;
		s_s8  <= mul30(x_s7, u_s7);
		x_s4 <= x_s3; x_s5 <= x_s4; x_s6 <= x_s5; x_s7 <= x_s6;
		x2_s5 <= x2_s4; x2_s6 <= x2_s5;
		quad_s3 <= quad_s2; quad_s4 <= quad_s3; quad_s5 <= quad_s4;
		quad_s6 <= quad_s5; quad_s7 <= quad_s6; quad_s8 <= quad_s7;
		swap_s3 <= swap_s2; swap_s4 <= swap_s3; swap_s5 <= swap_s4;
		swap_s6 <= swap_s5; swap_s7 <= swap_s6; swap_s8 <= swap_s7;
		unique case (quad_s8)
			2'd0: begin
				cos_o <= $signed({1'b0, c0});
				sin_o <= $signed({1'b0, s0});
			end
			2'd1: begin
				cos_o <= -$signed({1'b0, s0});
				sin_o <= $signed({1'b0, c0});
			end
			2'd2: begin
				cos_o <= -$signed({1'b0, c0});
				sin_o <= -$signed({1'b0, s0});
			end
			default: begin
				cos_o <= $signed({1'b0, s0});
				sin_o <= -$signed({1'b0, c0});
			end
		endcase
	end

endmodule

[rtl/ttc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module ttc_div
	import ttc_pkg::*;
#(
	parameter int unsigned NUM_W = TDN_NUM_W,
	parameter int unsigned DEN_W = DIV_DEN_W
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quot
);

	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W-1:0] rin;
		logic [NUM_W-1:0] nin;
		logic [DEN_W-1:0] din;
		logic [DEN_W:0]   trial;
		if (i == 0) begin : g_first
			assign rin = '0;
			assign nin = num;
			assign din = den;
		end else begin : g_next
			assign rin = rem_s[i-1];
			assign nin = nq_s[i-1];
			assign din = den_s[i-1];
		end
		assign trial = {rin, nin[NUM_W-1]};
		always_ff @(posedge clk) begin
			den_s[i] <= din;
			if (trial >= {1'b0, din}) begin
				rem_s[i] <= DEN_W'(trial - {1'b0, din});
				nq_s[i]  <= {nin[NUM_W-2:0], 1'b1};
			end else begin
				rem_s[i] <= trial[DEN_W-1:0];
				nq_s[i]  <= {nin[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quot = nq_s[NUM_W-1];

endmodule
